// ----- sv/flpk_pkg.sv -----
package flpk_pkg;

    // Lot ring geometry
    localparam int LOTS  = 64;
    localparam int IDX_W = (LOTS > 1) ? $clog2(LOTS) : 1;
    localparam int CNT_W = $clog2(LOTS + 1);

    // Field widths
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 24;
    localparam int POS_W   = 32;
    localparam int BASIS_W = 63;
    localparam int VAL_W   = 64;

    // Action codes
    localparam logic [1:0] ACT_BUY  = 2'd0;
    localparam logic [1:0] ACT_SELL = 2'd1;
    localparam logic [1:0] ACT_MARK = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_OVERSOLD = 2'd2;

    // One purchase lot
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   shares;
    } t_lot;

    // Ring index advance with wrap
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(LOTS - 1)) begin
            res = '0;
        end else begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

endpackage

// ----- sv/flpk_lot_ram.sv -----
module flpk_lot_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [flpk_pkg::IDX_W-1:0] i_waddr,
    input  flpk_pkg::t_lot            i_wdata,
    input  logic                      i_re,
    input  logic [flpk_pkg::IDX_W-1:0] i_raddr,
    output flpk_pkg::t_lot            o_rdata
);

    flpk_pkg::t_lot r_mem [flpk_pkg::LOTS];
    flpk_pkg::t_lot r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/fifo_lot_position_keeper.sv -----
// From start accepted to o_valid, a mark or refused buy runs S_MV_MUL, S_OUT; a buy
// runs S_BUY_MUL, S_BUY_UPD first; a sell runs S_SEL_CHK and, per lot touched,
// S_SEL_RD, S_SEL_UPD (read, multiply, update of the shared multiplier loop) first.
// busy stays high, refusing start, until the result is registered. The receiver cannot stall.
// Reset (synchronous, active low) empties the ring and clears position, basis and
// price; lot storage is not cleared and no clearing pass is needed.
module fifo_lot_position_keeper (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_action,
    input  logic [31:0]         i_price,
    input  logic [23:0]         i_share_count,
    output logic                o_valid,
    output logic signed [31:0]  o_held_shares,
    output logic signed [63:0]  o_position_value,
    output logic [62:0]         o_cost_total,
    output logic signed [63:0]  o_gain_loss,
    output logic [1:0]          o_status
);

    localparam int IDX_W   = flpk_pkg::IDX_W;
    localparam int CNT_W   = flpk_pkg::CNT_W;
    localparam int PRICE_W = flpk_pkg::PRICE_W;
    localparam int QTY_W   = flpk_pkg::QTY_W;
    localparam int POS_W   = flpk_pkg::POS_W;
    localparam int BASIS_W = flpk_pkg::BASIS_W;
    localparam int VAL_W   = flpk_pkg::VAL_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_BUY_MUL = 3'd1;
    localparam logic [2:0] S_BUY_UPD = 3'd2;
    localparam logic [2:0] S_SEL_CHK = 3'd3;
    localparam logic [2:0] S_SEL_RD  = 3'd4;
    localparam logic [2:0] S_SEL_UPD = 3'd5;
    localparam logic [2:0] S_MV_MUL  = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    logic [2:0]              r_state, n_state;
    logic [PRICE_W-1:0]      r_price;
    logic [QTY_W-1:0]        r_qty;
    logic [QTY_W-1:0]        r_left, n_left;
    logic                    r_all;
    logic [1:0]              r_act;
    logic [1:0]              r_status, n_status;
    logic [IDX_W-1:0]        r_head, n_head;
    logic [IDX_W-1:0]        r_tail, n_tail;
    logic [CNT_W-1:0]        r_count, n_count;
    logic signed [POS_W-1:0] r_pos, n_pos;
    logic [BASIS_W-1:0]      r_basis, n_basis;
    logic [PRICE_W-1:0]      r_last_price, n_last_price;
    logic [VAL_W-1:0]        r_prod;
    logic                    r_valid;

    logic                    accept;
    logic                    ring_full;
    flpk_pkg::t_lot          rd_lot;
    flpk_pkg::t_lot          wr_lot;
    logic                    mem_we, mem_re;
    logic [IDX_W-1:0]        mem_waddr;
    logic [QTY_W-1:0]        used;
    logic signed [32:0]      mul_a, mul_b;
    logic signed [65:0]      mul_full;
    logic signed [POS_W+1:0] pos_sum;
    logic signed [POS_W+1:0] pos_step;
    logic [VAL_W-1:0]        basis_add;
    logic signed [VAL_W:0]   gl_diff;
    logic signed [VAL_W-1:0] gl_sat;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign ring_full = (r_count >= CNT_W'(flpk_pkg::LOTS));

    // Lot storage
    flpk_lot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (wr_lot),
        .i_re    (mem_re),
        .i_raddr (r_head),
        .o_rdata (rd_lot)
    );

    // Shares taken from the head lot
    assign used = (r_left < rd_lot.shares) ? r_left : rd_lot.shares;

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            S_BUY_MUL: begin
                mul_a = $signed({1'b0, r_price});
                mul_b = $signed({9'd0, r_qty});
            end
            S_SEL_RD: begin
                mul_a = $signed({1'b0, rd_lot.price});
                mul_b = $signed({9'd0, used});
            end
            default: begin
                mul_a = $signed({1'b0, r_last_price});
                mul_b = $signed({r_pos[POS_W-1], r_pos});
            end
        endcase
    end
    assign mul_full = mul_a * mul_b;

    // Memory write select
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_tail;
        wr_lot    = '{price: r_price, shares: r_qty};
        if (r_state == S_BUY_UPD) begin
            mem_we = 1'b1;
        end else if (r_state == S_SEL_UPD && !r_all) begin
            mem_we    = 1'b1;
            mem_waddr = r_head;
            wr_lot    = '{price: rd_lot.price, shares: rd_lot.shares - r_left};
        end
    end
    assign mem_re = (r_state == S_SEL_CHK) && (r_count != '0) && (r_left != '0);

    // Saturating position update: a sell at accept, a buy from its stored count
    always_comb begin
        if (r_state == S_IDLE) begin
            pos_step = $signed({10'd0, i_share_count});
            pos_sum  = $signed({{2{r_pos[POS_W-1]}}, r_pos}) - pos_step;
        end else begin
            pos_step = $signed({10'd0, r_qty});
            pos_sum  = $signed({{2{r_pos[POS_W-1]}}, r_pos}) + pos_step;
        end
    end

    assign basis_add = {1'b0, r_basis} + r_prod;

    // Gain and loss; only the low side can overflow
    assign gl_diff = $signed({r_prod[VAL_W-1], r_prod}) - $signed({2'b00, r_basis});
    always_comb begin
        if (gl_diff[VAL_W] && !gl_diff[VAL_W-1]) begin
            gl_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            gl_sat = gl_diff[VAL_W-1:0];
        end
    end

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_left       = r_left;
        n_status     = r_status;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_pos        = r_pos;
        n_basis      = r_basis;
        n_last_price = r_last_price;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = flpk_pkg::ST_OK;
                    n_left   = i_share_count;
                    case (i_action)
                        flpk_pkg::ACT_BUY: begin
                            if (ring_full) begin
                                n_status = flpk_pkg::ST_FULL;
                                n_state  = S_MV_MUL;
                            end else begin
                                n_state = S_BUY_MUL;
                            end
                        end
                        flpk_pkg::ACT_SELL: begin
                            n_last_price = i_price;
                            if (pos_sum < -(34'sd2147483648)) begin
                                n_pos = {1'b1, {(POS_W-1){1'b0}}};
                            end else begin
                                n_pos = pos_sum[POS_W-1:0];
                            end
                            n_state = S_SEL_CHK;
                        end
                        flpk_pkg::ACT_MARK: begin
                            n_last_price = i_price;
                            n_state      = S_MV_MUL;
                        end
                        default: begin
                            n_state = S_MV_MUL;
                        end
                    endcase
                end
            end
            S_BUY_MUL: begin
                n_state = S_BUY_UPD;
            end
            S_BUY_UPD: begin
                n_last_price = r_price;
                if (pos_sum > 34'sd2147483647) begin
                    n_pos = {1'b0, {(POS_W-1){1'b1}}};
                end else begin
                    n_pos = pos_sum[POS_W-1:0];
                end
                if (basis_add[VAL_W-1]) begin
                    n_basis = '1;
                end else begin
                    n_basis = basis_add[BASIS_W-1:0];
                end
                n_tail  = flpk_pkg::next_idx(r_tail);
                n_count = r_count + CNT_W'(1);
                n_state = S_MV_MUL;
            end
            S_SEL_CHK: begin
                if (mem_re) begin
                    n_state = S_SEL_RD;
                end else begin
                    if (r_left != '0) begin
                        n_status = flpk_pkg::ST_OVERSOLD;
                    end
                    n_state = S_MV_MUL;
                end
            end
            S_SEL_RD: begin
                n_state = S_SEL_UPD;
            end
            S_SEL_UPD: begin
                if (r_prod > {1'b0, r_basis}) begin
                    n_basis = '0;
                end else begin
                    n_basis = r_basis - r_prod[BASIS_W-1:0];
                end
                if (r_all) begin
                    n_left  = r_left - rd_lot.shares;
                    n_head  = flpk_pkg::next_idx(r_head);
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_left = '0;
                end
                n_state = S_SEL_CHK;
            end
            S_MV_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_pos        <= '0;
            r_basis      <= '0;
            r_last_price <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_pos        <= n_pos;
            r_basis      <= n_basis;
            r_last_price <= n_last_price;
            r_valid      <= (r_state == S_OUT);
        end
    end

    // Transaction payload and working registers
    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_status <= n_status;
        r_prod   <= mul_full[VAL_W-1:0];
        if (accept) begin
            r_act   <= i_action;
            r_price <= i_price;
            r_qty   <= i_share_count;
        end
        if (r_state == S_SEL_RD) begin
            r_all <= (r_left >= rd_lot.shares);
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            o_held_shares    <= r_pos;
            o_position_value <= r_prod;
            o_cost_total     <= r_basis;
            o_gain_loss      <= gl_sat;
            o_status         <= r_status;
        end
    end

    assign o_valid = r_valid;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(flpk_pkg::LOTS))
        else $error("lot count beyond ring size");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(r_state == S_OUT))
        else $error("result strobe without finishing a transaction");

    a_full_only_buy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == flpk_pkg::ST_FULL) |-> (r_act == flpk_pkg::ACT_BUY))
        else $error("full status on a non-buy transaction");

    a_ring_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty ring with head and tail apart");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule
